// ===== hw/rtl/imh_pkg.sv =====
// Package for the indexed min-heap: sizes, operation and status codes,
// heap entry type and controller states. No dependencies.
package imh_pkg;

  localparam int unsigned KEYS    = 32;
  localparam int unsigned KeyW    = 5;
  localparam int unsigned ValW    = 32;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned AddrW   = $clog2(KEYS);      // slot - 1
  localparam int unsigned SlotW   = $clog2(KEYS + 1);  // slot 1..KEYS, also count

  typedef enum logic [FuncW-1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_UPSERT  = 2'd1,
    FUNC_EXTRACT = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_REFUSED  = 2'd2,
    ST_INCREASE = 2'd3
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0]        key;
    logic signed [ValW-1:0] value;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_EX,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_e;

endpackage

// ===== hw/rtl/imh_req_if.sv =====
// Request channel of the indexed min-heap: valid/ready plus one operation.
// Depends on imh_pkg.
interface imh_req_if;
  import imh_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FuncW-1:0]       func;
  logic [KeyW-1:0]        item_key;
  logic signed [ValW-1:0] item_value;

  modport source (output valid, func, item_key, item_value, input ready);
  modport sink   (input valid, func, item_key, item_value, output ready);
endinterface

// ===== hw/rtl/imh_rsp_if.sv =====
// Response channel of the indexed min-heap: valid/ready plus one result.
// Depends on imh_pkg.
interface imh_rsp_if;
  import imh_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KeyW-1:0]        min_key;
  logic signed [ValW-1:0] min_value;
  logic [StatusW-1:0]     status;
  logic [SlotW-1:0]       count;

  modport source (output valid, min_key, min_value, status, count, input ready);
  modport sink   (input valid, min_key, min_value, status, count, output ready);
endinterface

// ===== hw/rtl/indexed_min_heap_decrease_key.sv =====
// Indexed binary min-heap with decrease-key: controller, heap memory and
// key-to-slot memory. Depends on imh_pkg, imh_req_if and imh_rsp_if.
//
// One request transaction is taken at a time and answered by exactly one
// response transaction. Clear, an unused code and an extract from an empty
// heap go straight to the response; a refused insert passes through S_INS,
// an ignored increase or an unchanged value through S_INS and S_CMP.
// Otherwise each level of sift-up or sift-down is one read step and one
// compare/write step, and at most 5 levels are moved for 32 entries. After
// the response is loaded the controller returns to S_IDLE before it takes
// the next request. The next request is accepted while the previous response
// still waits in the output register. Heap entries live in a 32-entry memory
// with two read ports; key positions live in a second 32-entry memory plus
// one presence bit per key, which reset and clear zero at once, so no
// clearing pass is needed.
module indexed_min_heap_decrease_key (
  input  logic       clk_i,
  input  logic       rst_ni,
  imh_req_if.sink    req_i,
  imh_rsp_if.source  rsp_o
);
  import imh_pkg::*;

  // memories
  entry_t           heap_mem [KEYS];
  logic [AddrW-1:0] slot_mem [KEYS];

  state_e state_q, state_d;

  logic [KeyW-1:0]        key_q, key_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic [SlotW-1:0]       slot_q, slot_d;
  logic [SlotW-1:0]       size_q, size_d;
  logic [KEYS-1:0]        kvalid_q, kvalid_d;

  logic [KeyW-1:0]        res_key_q, res_key_d;
  logic signed [ValW-1:0] res_val_q, res_val_d;
  status_e                res_status_q, res_status_d;

  logic                   rsp_valid_q, rsp_valid_d;
  logic [KeyW-1:0]        rsp_key_q, rsp_key_d;
  logic signed [ValW-1:0] rsp_val_q, rsp_val_d;
  logic [StatusW-1:0]     rsp_status_q, rsp_status_d;
  logic [SlotW-1:0]       rsp_count_q, rsp_count_d;

  // memory ports
  logic [AddrW-1:0] rd_a_addr, rd_b_addr;
  entry_t           rd_a_q, rd_b_q;
  logic             hm_we;
  logic [AddrW-1:0] hm_waddr;
  entry_t           hm_wdata;
  logic             sm_we;
  logic [KeyW-1:0]  sm_waddr;
  logic [AddrW-1:0] sm_wdata;
  logic [AddrW-1:0] sm_rd_q;
  logic             do_place;

  logic             req_acc;
  logic             rsp_load;
  logic [SlotW-1:0] found_slot;
  logic             present;
  logic [SlotW:0]   child_c, child_c1;
  logic             dn_has_c, pick_b, dn_move, up_move;
  entry_t           child;
  logic [SlotW-1:0] child_slot;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign rsp_load    = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);

  assign found_slot = {1'b0, sm_rd_q} + SlotW'(1);
  assign present    = kvalid_q[key_q] && (found_slot <= size_q);

  // sift-down child selection; left child wins ties
  assign child_c    = {slot_q, 1'b0};
  assign child_c1   = child_c + (SlotW+1)'(1);
  assign dn_has_c   = child_c <= {1'b0, size_q};
  assign pick_b     = (child_c1 <= {1'b0, size_q}) && (rd_b_q.value < rd_a_q.value);
  assign child      = pick_b ? rd_b_q : rd_a_q;
  assign child_slot = pick_b ? child_c1[SlotW-1:0] : child_c[SlotW-1:0];
  assign dn_move    = child.value < val_q;
  assign up_move    = val_q < rd_a_q.value;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          case (req_i.func)
            FUNC_UPSERT:  state_d = S_INS;
            FUNC_EXTRACT: state_d = (size_q == '0) ? S_DONE : S_EX;
            default:      state_d = S_DONE;
          endcase
        end
      end
      S_INS: begin
        if (present) begin
          state_d = S_CMP;
        end else if (size_q >= SlotW'(KEYS)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_UP_RD;
        end
      end
      S_CMP:    state_d = (val_q < rd_a_q.value) ? S_UP_RD : S_DONE;
      S_UP_RD:  state_d = (slot_q > SlotW'(1)) ? S_UP_CMP : S_DONE;
      S_UP_CMP: state_d = up_move ? S_UP_RD : S_DONE;
      S_EX:     state_d = (size_q == SlotW'(1)) ? S_DONE : S_DN_RD;
      S_DN_RD:  state_d = dn_has_c ? S_DN_CMP : S_DONE;
      S_DN_CMP: state_d = dn_move ? S_DN_RD : S_DONE;
      S_DONE:   state_d = rsp_load ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    key_d        = key_q;
    val_d        = val_q;
    slot_d       = slot_q;
    size_d       = size_q;
    kvalid_d     = kvalid_q;
    res_key_d    = res_key_q;
    res_val_d    = res_val_q;
    res_status_d = res_status_q;
    rd_a_addr    = '0;
    rd_b_addr    = '0;
    hm_we        = 1'b0;
    hm_waddr     = '0;
    hm_wdata     = '0;
    sm_we        = 1'b0;
    sm_waddr     = '0;
    sm_wdata     = '0;
    do_place     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          key_d        = req_i.item_key;
          val_d        = req_i.item_value;
          res_key_d    = '0;
          res_val_d    = '0;
          res_status_d = ST_OK;
          rd_a_addr    = '0;
          rd_b_addr    = AddrW'(size_q - SlotW'(1));
          case (req_i.func)
            FUNC_CLEAR: begin
              kvalid_d = '0;
              size_d   = '0;
            end
            FUNC_EXTRACT: begin
              if (size_q == '0) res_status_d = ST_EMPTY;
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        if (present) begin
          slot_d    = found_slot;
          rd_a_addr = sm_rd_q;
        end else if (size_q >= SlotW'(KEYS)) begin
          res_status_d = ST_REFUSED;
        end else begin
          size_d = size_q + SlotW'(1);
          slot_d = size_q + SlotW'(1);
        end
      end
      S_CMP: begin
        if (val_q > rd_a_q.value) res_status_d = ST_INCREASE;
      end
      S_UP_RD: begin
        if (slot_q > SlotW'(1)) begin
          rd_a_addr = AddrW'((slot_q >> 1) - SlotW'(1));
        end else begin
          do_place = 1'b1;
        end
      end
      S_UP_CMP: begin
        if (up_move) begin
          // parent moves down into the current slot
          hm_we    = 1'b1;
          hm_waddr = AddrW'(slot_q - SlotW'(1));
          hm_wdata = rd_a_q;
          sm_we    = 1'b1;
          sm_waddr = rd_a_q.key;
          sm_wdata = AddrW'(slot_q - SlotW'(1));
          slot_d   = slot_q >> 1;
        end else begin
          do_place = 1'b1;
        end
      end
      S_EX: begin
        // rd_a holds the root, rd_b the last entry
        res_key_d          = rd_a_q.key;
        res_val_d          = rd_a_q.value;
        kvalid_d[rd_a_q.key] = 1'b0;
        key_d              = rd_b_q.key;
        val_d              = rd_b_q.value;
        size_d             = size_q - SlotW'(1);
        slot_d             = SlotW'(1);
      end
      S_DN_RD: begin
        if (dn_has_c) begin
          rd_a_addr = AddrW'(child_c - (SlotW+1)'(1));
          rd_b_addr = AddrW'(child_c);
        end else begin
          do_place = 1'b1;
        end
      end
      S_DN_CMP: begin
        if (dn_move) begin
          hm_we    = 1'b1;
          hm_waddr = AddrW'(slot_q - SlotW'(1));
          hm_wdata = child;
          sm_we    = 1'b1;
          sm_waddr = child.key;
          sm_wdata = AddrW'(slot_q - SlotW'(1));
          slot_d   = child_slot;
        end else begin
          do_place = 1'b1;
        end
      end
      S_DONE: ;
      default: ;
    endcase

    // final placement of the moving entry
    if (do_place) begin
      hm_we           = 1'b1;
      hm_waddr        = AddrW'(slot_q - SlotW'(1));
      hm_wdata.key    = key_q;
      hm_wdata.value  = val_q;
      sm_we           = 1'b1;
      sm_waddr        = key_q;
      sm_wdata        = AddrW'(slot_q - SlotW'(1));
      kvalid_d[key_q] = 1'b1;
    end
  end

  // output register
  always_comb begin
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_key_d    = rsp_key_q;
    rsp_val_d    = rsp_val_q;
    rsp_status_d = rsp_status_q;
    rsp_count_d  = rsp_count_q;
    if (rsp_load) begin
      rsp_valid_d  = 1'b1;
      rsp_key_d    = res_key_q;
      rsp_val_d    = res_val_q;
      rsp_status_d = res_status_q;
      rsp_count_d  = size_q;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.min_key   = rsp_key_q;
  assign rsp_o.min_value = rsp_val_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.count     = rsp_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      size_q       <= '0;
      kvalid_q     <= '0;
      rsp_valid_q  <= 1'b0;
      res_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      size_q       <= size_d;
      kvalid_q     <= kvalid_d;
      rsp_valid_q  <= rsp_valid_d;
      res_status_q <= res_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    val_q        <= val_d;
    slot_q       <= slot_d;
    res_key_q    <= res_key_d;
    res_val_q    <= res_val_d;
    rsp_key_q    <= rsp_key_d;
    rsp_val_q    <= rsp_val_d;
    rsp_status_q <= rsp_status_d;
    rsp_count_q  <= rsp_count_d;
  end

  // heap memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (hm_we) heap_mem[hm_waddr] <= hm_wdata;
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  // key-to-slot memory, read once per accepted transaction
  always_ff @(posedge clk_i) begin
    if (sm_we) slot_mem[sm_waddr] <= sm_wdata;
    if (req_acc) sm_rd_q <= slot_mem[req_i.item_key];
  end

  // checks
  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q <= SlotW'(KEYS))
    else $error("heap size above capacity");

  a_keys_match_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(kvalid_q) == int'(size_q)))
    else $error("present keys do not match heap size");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q != S_IDLE))
    else $error("controller idle right after accepting a transaction");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_status_q == ST_EMPTY) |->
      (rsp_count_q == '0 && rsp_key_q == '0 && rsp_val_q == '0))
    else $error("empty extract reported a key or nonzero count");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |=> $stable(rsp_count_q) && $stable(rsp_key_q))
    else $error("pending response overwritten");

endmodule
